// ----- hw/rtl/lprs_pkg.sv -----
`timescale 1ns / 1ps

package lprs_pkg;

  // panel geometry
  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 32;
  localparam int CHANNELS     = 8;
  localparam int BANK_DEPTH   = 512;

  localparam int ADDR_W  = 12;  // pixel_address
  localparam int COLOR_W = 3;   // color
  localparam int POS_W   = 9;   // shift_position, bank index
  localparam int BANK_W  = 3;   // bank select
  localparam int COL_W   = 7;   // column bits of the row-major address
  localparam int ROW_W   = ADDR_W - COL_W;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 40;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SHIFT = 1'b1
  } op_e;

  // one write port of a channel bank
  typedef struct packed {
    logic               en;
    logic [POS_W-1:0]   addr;
    logic [COLOR_W-1:0] data;
  } bank_wr_t;

endpackage

// ----- hw/rtl/lprs_remap.sv -----
`timescale 1ns / 1ps

module lprs_remap (
  input  logic [lprs_pkg::ADDR_W-1:0] pixel_address_i,
  output logic [lprs_pkg::BANK_W-1:0] bank_o,
  output logic [lprs_pkg::POS_W-1:0]  index_o
);
  import lprs_pkg::*;

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [1:0]        c;
  logic [3:0]        offset;
  logic [ADDR_W-1:0] dst;

  assign col = pixel_address_i[COL_W-1:0];
  assign row = pixel_address_i[ADDR_W-1:COL_W];
  assign c   = col[1:0];

  // group rows 0/1 run mirrored (2*(3-c)), rows 2/3 forward (8+2c), odd offset on rows 1 and 2
  assign offset = {row[1], (row[1] ? c : ~c), row[1] ^ row[0]};

  // group index = col/4 + (row/4)*32, 16 entries per group
  assign dst = {row[ROW_W-1:2], col[COL_W-1:2], offset};

  assign bank_o  = dst[ADDR_W-1:POS_W];
  assign index_o = dst[POS_W-1:0];

endmodule

// ----- hw/rtl/lprs_bank.sv -----
`timescale 1ns / 1ps

module lprs_bank (
  input  logic                         clk_i,
  input  lprs_pkg::bank_wr_t           wr_i,
  input  logic                         rd_en_i,
  input  logic [lprs_pkg::POS_W-1:0]   rd_addr_i,
  output logic [lprs_pkg::COLOR_W-1:0] rd_data_o
);
  import lprs_pkg::*;

  logic [COLOR_W-1:0] mem_q [BANK_DEPTH];
  logic [COLOR_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hw/rtl/led_panel_remap_and_shift_out_core.sv -----
`timescale 1ns / 1ps
// output: a shift beat shows on the master side in the cycle after it is taken
// throughput: one beat per cycle, write or shift, while the master side does not stall and no
//   clearing pass runs, set by the single read and write port of each of the eight channel banks
// reset: position counter to zero, then a clearing pass blanks all banks in parallel,
//   one row a cycle, with s_axis_tready_o held low

module led_panel_remap_and_shift_out_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave side
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // pixel_address[11:0], color[14:12], scan_line[15]
  input  logic [lprs_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // operation[0]
  input  logic                               s_axis_tuser_i,
  // master side
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // red_bits[7:0], green_bits[15:8], blue_bits[23:16], shift_position[32:24], zero[39:33]
  output logic [lprs_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  // last_of_line
  output logic                               m_axis_tlast_o
);
  import lprs_pkg::*;

  // input fields
  op_e                op;
  logic [ADDR_W-1:0]  pixel_address;
  logic [COLOR_W-1:0] color;

  assign op            = op_e'(s_axis_tuser_i);
  assign pixel_address = s_axis_tdata_i[ADDR_W-1:0];
  assign color         = s_axis_tdata_i[ADDR_W +: COLOR_W];
  // scan_line (top bit) has no effect: static scan uses line zero only

  // clearing pass after reset
  logic             clear_q, clear_d;
  logic [POS_W-1:0] clr_cnt_q, clr_cnt_d;

  // running shift position and output stage
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] out_pos_q;
  logic             out_valid_q, out_valid_d;

  logic in_acc, wr_acc, sh_acc;

  // input moves whenever no clearing pass runs and the output stage is free or drains this cycle
  assign s_axis_tready_o = !clear_q && (!out_valid_q || m_axis_tready_i);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_acc = in_acc && (op == OP_WRITE);
  assign sh_acc = in_acc && (op == OP_SHIFT);

  // address remap for writes
  logic [BANK_W-1:0] wr_bank;
  logic [POS_W-1:0]  wr_index;

  lprs_remap u_remap (
    .pixel_address_i (pixel_address),
    .bank_o          (wr_bank),
    .index_o         (wr_index)
  );

  // channel banks: bank n holds entries n*512 .. n*512+511
  bank_wr_t           bank_wr   [CHANNELS];
  logic [COLOR_W-1:0] bank_rd   [CHANNELS];

  for (genvar g = 0; g < CHANNELS; g++) begin : g_bank
    always_comb begin
      bank_wr[g].en   = clear_q || (wr_acc && (wr_bank == BANK_W'(g)));
      bank_wr[g].addr = clear_q ? clr_cnt_q : wr_index;
      bank_wr[g].data = clear_q ? '0 : color;
    end

    // a write lands at its accept edge, so a shift read taken later sees it
    lprs_bank u_bank (
      .clk_i     (clk_i),
      .wr_i      (bank_wr[g]),
      .rd_en_i   (sh_acc),
      .rd_addr_i (pos_q),
      .rd_data_o (bank_rd[g])
    );
  end

  // control next state
  always_comb begin
    clear_d     = clear_q;
    clr_cnt_d   = clr_cnt_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;

    if (clear_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == POS_W'(BANK_DEPTH - 1)) begin
        clear_d = 1'b0;
      end
    end

    // counter wraps at 512 by its width
    if (sh_acc) begin
      pos_d       = pos_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q     <= 1'b1;
      clr_cnt_q   <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clear_q     <= clear_d;
      clr_cnt_q   <= clr_cnt_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // position travels beside the bank read data
  always_ff @(posedge clk_i) begin
    if (sh_acc) begin
      out_pos_q <= pos_q;
    end
  end

  // gather color planes across channels
  logic [CHANNELS-1:0] red_bits, green_bits, blue_bits;

  always_comb begin
    for (int n = 0; n < CHANNELS; n++) begin
      red_bits[n]   = bank_rd[n][0];
      green_bits[n] = bank_rd[n][1];
      blue_bits[n]  = bank_rd[n][2];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(M_TDATA_W - 3*CHANNELS - POS_W)'(0), out_pos_q,
                            blue_bits, green_bits, red_bits};
  assign m_axis_tlast_o  = (out_pos_q == POS_W'(BANK_DEPTH - 1));

  // no beat taken while the banks are being blanked
  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q |-> !in_acc)
    else $error("beat accepted during clearing pass");

  // a pending result always sits one position behind the counter
  a_pos_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (pos_q == out_pos_q + 1'b1))
    else $error("shift counter out of step with pending result");

  // a shift beat always produces a result next cycle
  a_shift_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sh_acc |=> out_valid_q)
    else $error("shift beat lost");

  // write beats leave the shift counter untouched
  a_write_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_acc |=> (pos_q == $past(pos_q)))
    else $error("write beat moved the shift position");

endmodule

// ----- test/led_panel_remap_and_shift_out_core_checker.sv -----
`timescale 1ns / 1ps

module led_panel_remap_and_shift_out_core_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  // pixel_address[11:0], color[14:12], scan_line[15]
  input  logic [lprs_pkg::S_TDATA_W-1:0] s_tdata_i,
  // operation[0]
  input  logic                           s_tuser_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  // red_bits[7:0], green_bits[15:8], blue_bits[23:16], shift_position[32:24], zero[39:33]
  input  logic [lprs_pkg::M_TDATA_W-1:0] m_tdata_i,
  // last_of_line
  input  logic                           m_tlast_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             compared_o,
  output int                             wraps_o
);
  import lprs_pkg::*;

  localparam int STORE_DEPTH    = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int GROUPS_ACROSS  = PANEL_WIDTH / 4;
  localparam int GROUP_ROW1_OFS = 1;
  localparam int GROUP_ROW2_OFS = 9;
  localparam int GROUP_ROW3_OFS = 8;

  typedef struct packed {
    logic [CHANNELS-1:0] red;
    logic [CHANNELS-1:0] green;
    logic [CHANNELS-1:0] blue;
    logic [POS_W-1:0]    pos;
    logic                last;
  } line_beat_t;

  logic [COLOR_W-1:0] pixel_mem [STORE_DEPTH];
  logic [POS_W-1:0]   scan_pos;
  line_beat_t         expected_beats [$];
  line_beat_t         exp_beat;
  line_beat_t         got_beat;
  logic [ADDR_W-1:0]  wr_pixel;

  // row-major pixel to store slot: 4x4 groups, top two rows mirrored
  function automatic logic [ADDR_W-1:0] store_index(input logic [ADDR_W-1:0] pix);
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [1:0]        c;
    logic [ADDR_W-1:0] base;
    col  = pix[COL_W-1:0];
    row  = pix[ADDR_W-1:COL_W];
    c    = col[1:0];
    base = ADDR_W'(16 * ((col >> 2) + (row >> 2) * GROUPS_ACROSS));
    case (row[1:0])
      2'd0:    store_index = base + ADDR_W'(2 * (3 - c));
      2'd1:    store_index = base + ADDR_W'(GROUP_ROW1_OFS + 2 * (3 - c));
      2'd2:    store_index = base + ADDR_W'(GROUP_ROW2_OFS + 2 * c);
      default: store_index = base + ADDR_W'(GROUP_ROW3_OFS + 2 * c);
    endcase
  endfunction

  // one slot per channel bank at the running position
  function automatic line_beat_t predict_line(input logic [POS_W-1:0] pos);
    line_beat_t         beat;
    logic [COLOR_W-1:0] px;
    int                 idx;
    beat = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      idx = int'(pos) + ch * BANK_DEPTH;
      px  = (idx < STORE_DEPTH) ? pixel_mem[idx] : '0;
      beat.red[ch]   = px[0];
      beat.green[ch] = px[1];
      beat.blue[ch]  = px[2];
    end
    beat.pos  = pos;
    beat.last = (int'(pos) == BANK_DEPTH - 1);
    return beat;
  endfunction

  task automatic check_field(input string name, input logic [POS_W-1:0] exp_v,
                             input logic [POS_W-1:0] act_v);
    if (act_v !== exp_v) begin
      fail_count_o++;
      $display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      foreach (pixel_mem[i]) pixel_mem[i] = '0;
      scan_pos = '0;
      expected_beats.delete();
      fail_count_o = 0;
      compared_o   = 0;
      wraps_o      = 0;
    end else begin
      // output side first: a beat taken now cannot show before the next edge
      if (m_tvalid_i && m_tready_i) begin
        got_beat = '{red:   m_tdata_i[7:0],
                     green: m_tdata_i[15:8],
                     blue:  m_tdata_i[23:16],
                     pos:   m_tdata_i[32:24],
                     last:  m_tlast_i};
        if (expected_beats.size() == 0) begin
          fail_count_o++;
          $display("%0t: shift beat expected none got tdata %h tlast %b",
                   $time, m_tdata_i, m_tlast_i);
        end else begin
          exp_beat = expected_beats.pop_front();
          check_field("red_bits", POS_W'(exp_beat.red), POS_W'(got_beat.red));
          check_field("green_bits", POS_W'(exp_beat.green), POS_W'(got_beat.green));
          check_field("blue_bits", POS_W'(exp_beat.blue), POS_W'(got_beat.blue));
          check_field("shift_position", exp_beat.pos, got_beat.pos);
          check_field("last_of_line", POS_W'(exp_beat.last), POS_W'(got_beat.last));
          check_field("tdata pad", '0, POS_W'(m_tdata_i[M_TDATA_W-1:33]));
          compared_o++;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (op_e'(s_tuser_i) == OP_SHIFT) begin
          expected_beats.push_back(predict_line(scan_pos));
          if (int'(scan_pos) == BANK_DEPTH - 1) begin
            scan_pos = '0;
            wraps_o++;
          end else begin
            scan_pos = scan_pos + 1'b1;
          end
        end else begin
          // scan_line is ignored, static scan has a single line
          wr_pixel = s_tdata_i[ADDR_W-1:0];
          if (int'(wr_pixel) < STORE_DEPTH)
            pixel_mem[store_index(wr_pixel)] = s_tdata_i[ADDR_W+COLOR_W-1:ADDR_W];
        end
      end
    end
    pending_o = expected_beats.size();
  end

endmodule

// ----- test/led_panel_remap_and_shift_out_core_tb.sv -----
`timescale 1ns / 1ps

module led_panel_remap_and_shift_out_core_tb;
  import lprs_pkg::*;

  localparam int RANDOM_ITEMS     = 1300;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 20;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic                 s_axis_tuser_i  = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic                 m_axis_tlast_o;

  logic src_gaps_on   = 1'b1;
  logic sink_gaps_on  = 1'b1;
  logic sink_hold_req = 1'b0;

  int fail_count;
  int pending;
  int compared;
  int wraps;
  int writes_sent = 0;
  int shifts_sent = 0;

  led_panel_remap_and_shift_out_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  led_panel_remap_and_shift_out_core_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .s_tuser_i    (s_axis_tuser_i),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_i    (m_axis_tdata_o),
    .m_tlast_i    (m_axis_tlast_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .compared_o   (compared),
    .wraps_o      (wraps)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("led_panel_remap_and_shift_out_core_tb failed");
    $finish;
  end

  // offer one beat, with random gaps in front, and wait until it is taken
  task automatic send_beat(input op_e op, input logic [ADDR_W-1:0] pix,
                           input logic [COLOR_W-1:0] color, input logic scan);
    while (src_gaps_on && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {scan, color, pix};
    s_axis_tuser_i  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (op == OP_SHIFT) shifts_sent++;
    else writes_sent++;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk_i);
        sink_hold_req = 1'b0;
      end
      m_axis_tready_i <= !sink_gaps_on || ($urandom_range(0, 99) >= 30);
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] pix;
    int                sel;
    op_e               op;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners and every row phase of a group, shift fields set high too
    send_beat(OP_WRITE, 12'd0,    3'd7, 1'b0);
    send_beat(OP_WRITE, 12'd128,  3'd1, 1'b1);
    send_beat(OP_WRITE, 12'd256,  3'd2, 1'b0);
    send_beat(OP_WRITE, 12'd384,  3'd4, 1'b1);
    send_beat(OP_WRITE, 12'd3,    3'd5, 1'b0);
    send_beat(OP_WRITE, 12'd2048, 3'd7, 1'b1);
    send_beat(OP_WRITE, 12'd4095, 3'd7, 1'b1);
    send_beat(OP_WRITE, 12'd127,  3'd6, 1'b0);
    send_beat(OP_WRITE, 12'd3968, 3'd3, 1'b0);
    repeat (10) send_beat(OP_SHIFT, '1, '1, 1'b1);
    // overwrite a pixel with blank after it was read once
    send_beat(OP_WRITE, 12'd0,    3'd0, 1'b0);
    send_beat(OP_SHIFT, '0, '0, 1'b0);
    send_beat(OP_SHIFT, '0, '0, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      src_gaps_on  = !(n >= 500 && n < 800);
      sink_gaps_on = src_gaps_on;
      if (n == 200) sink_hold_req = 1'b1;
      sel = $urandom_range(0, 15);
      if (sel == 0) pix = '0;
      else if (sel == 1) pix = '1;
      else pix = ADDR_W'($urandom_range(0, 4095));
      op = ($urandom_range(0, 99) < 55) ? OP_SHIFT : OP_WRITE;
      send_beat(op, pix, COLOR_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end
    s_axis_tvalid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d pixel writes and %0d shift beats, %0d line beats compared",
             writes_sent, shifts_sent, compared);
    $display("position counter wrapped %0d times, with a %0d-cycle output hold-off",
             wraps, SINK_HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("led_panel_remap_and_shift_out_core_tb passed");
    end else begin
      $display("led_panel_remap_and_shift_out_core_tb failed");
    end
    $finish;
  end

endmodule
